// ===== rtl/core/drd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_pkg: detection row decode shared definitions
// Register indexes, reset values, column roles and the structs passed
// between the configuration file, the row tracker and the box pipeline.
// ----------------------------------------------------------------------------
package drd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCORE_THRESHOLD = 3'd0,
        REG_ROW_WIDTH       = 3'd1,
        REG_RATIO_X         = 3'd2,
        REG_RATIO_Y         = 3'd3,
        REG_IMAGE_WIDTH     = 3'd4,
        REG_IMAGE_HEIGHT    = 3'd5
    } cfg_index_t;

    localparam logic [12:0] RST_SCORE_THRESHOLD = 13'd1024;
    localparam logic [8:0]  RST_ROW_WIDTH       = 9'd85;
    localparam logic [23:0] RST_RATIO           = 24'd65536;
    localparam logic [15:0] RST_IMAGE_SIZE      = 16'd640;

    localparam logic [7:0] COL_BOX_X      = 8'd0;
    localparam logic [7:0] COL_BOX_Y      = 8'd1;
    localparam logic [7:0] COL_BOX_W      = 8'd2;
    localparam logic [7:0] COL_BOX_H      = 8'd3;
    localparam logic [7:0] COL_OBJECTNESS = 8'd4;
    localparam logic [7:0] COL_FIRST_CLASS = 8'd5;

    localparam logic [8:0]  ROW_WIDTH_MIN = 9'd6;
    localparam logic [12:0] SCORE_MAX     = 13'd4096;
    localparam int          SCORE_SHIFT   = 12;
    localparam int          CORNER_SHIFT  = 25;
    localparam int          CORNERS       = 4;

    typedef struct packed {
        logic [12:0] score_threshold;
        logic [8:0]  row_width;
        logic [23:0] ratio_x;
        logic [23:0] ratio_y;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic [23:0] box_x;
        logic [23:0] box_y;
        logic [23:0] box_w;
        logic [23:0] box_h;
        logic [23:0] objectness;
        logic [23:0] best_class_score;
        logic [7:0]  best_class;
    } row_t;

endpackage

// ===== rtl/core/drd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_cfg_regs: configuration register file
// Holds threshold, row width, scale ratios and clamp limits; writes to
// unused indexes are dropped.
// ----------------------------------------------------------------------------
module drd_cfg_regs
    import drd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_SCORE_THRESHOLD: cfg_next.score_threshold = cfg_data[12:0];
                REG_ROW_WIDTH:       cfg_next.row_width       = cfg_data[8:0];
                REG_RATIO_X:         cfg_next.ratio_x         = cfg_data[23:0];
                REG_RATIO_Y:         cfg_next.ratio_y         = cfg_data[23:0];
                REG_IMAGE_WIDTH:     cfg_next.image_width     = cfg_data[15:0];
                REG_IMAGE_HEIGHT:    cfg_next.image_height    = cfg_data[15:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.score_threshold <= RST_SCORE_THRESHOLD;
            cfg_reg.row_width       <= RST_ROW_WIDTH;
            cfg_reg.ratio_x         <= RST_RATIO;
            cfg_reg.ratio_y         <= RST_RATIO;
            cfg_reg.image_width     <= RST_IMAGE_SIZE;
            cfg_reg.image_height    <= RST_IMAGE_SIZE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/drd_row_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_row_track: column counter and row state
// Counts columns, latches box fields and objectness, tracks the first
// maximum class score and captures a row snapshot at row end.
// ----------------------------------------------------------------------------
module drd_row_track
    import drd_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    input  logic [23:0] sample,
    input  logic        frame_start,
    output logic        in_stall,
    input  logic        snap_ready,
    output logic        snap_valid,
    output row_t        snap
);

    localparam logic [8:0] ROW_WIDTH_MAX = 9'(MAX_ROW_WIDTH);

    logic [7:0] column_reg;
    logic [7:0] column_next;
    row_t       row_reg;
    row_t       row_next;
    logic       snap_valid_reg;
    row_t       snap_reg;
    logic [7:0] col;
    logic [8:0] row_width_eff;
    logic       row_last;
    logic       accept;

    assign in_stall = snap_valid_reg && !snap_ready;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        col = frame_start ? '0 : column_reg;

        if (cfg.row_width < ROW_WIDTH_MIN)
            row_width_eff = ROW_WIDTH_MIN;
        else if (cfg.row_width > ROW_WIDTH_MAX)
            row_width_eff = ROW_WIDTH_MAX;
        else
            row_width_eff = cfg.row_width;

        row_last = {1'b0, col} >= (row_width_eff - 9'd1);

        row_next = row_reg;
        case (col)
            COL_BOX_X:      row_next.box_x      = sample;
            COL_BOX_Y:      row_next.box_y      = sample;
            COL_BOX_W:      row_next.box_w      = sample;
            COL_BOX_H:      row_next.box_h      = sample;
            COL_OBJECTNESS: row_next.objectness = sample;
            COL_FIRST_CLASS:
            begin
                row_next.best_class_score = sample;
                row_next.best_class       = '0;
            end
            default:
            begin
                if ($signed(sample) > $signed(row_reg.best_class_score))
                begin
                    row_next.best_class_score = sample;
                    row_next.best_class       = col - COL_FIRST_CLASS;
                end
            end
        endcase

        column_next = row_last ? '0 : col + 8'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg     <= '0;
            row_reg        <= '0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                column_reg <= column_next;
                row_reg    <= row_next;
            end
            if (accept && row_last)
                snap_valid_reg <= 1'b1;
            else if (snap_ready)
                snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && row_last)
            snap_reg <= row_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

// ===== rtl/core/drd_box_pipe.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_box_pipe: score check and corner scaling pipeline
// Forms edge spans and the combined score, multiplies spans by the ratio
// in two halves, sums, then clamps corners into the output register.
// ----------------------------------------------------------------------------
module drd_box_pipe
    import drd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        snap_valid,
    input  row_t        snap,
    output logic        snap_ready,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [19:0] left,
    output logic [19:0] top,
    output logic [19:0] right,
    output logic [19:0] bottom,
    output logic [12:0] score,
    output logic [7:0]  class_id
);

    logic               b_valid_reg;
    logic signed [25:0] span_b_reg [CORNERS];
    logic signed [25:0] span_b_next [CORNERS];
    logic signed [47:0] prod_b_reg;
    logic signed [47:0] prod_b_next;
    logic               obj_ok_b_reg;
    logic               obj_ok_b_next;
    logic [7:0]         class_b_reg;

    logic               c_valid_reg;
    logic signed [38:0] lo_c_reg [CORNERS];
    logic signed [38:0] lo_c_next [CORNERS];
    logic signed [38:0] hi_c_reg [CORNERS];
    logic signed [38:0] hi_c_next [CORNERS];
    logic               pass_c_reg;
    logic               pass_c_next;
    logic [12:0]        score_c_reg;
    logic [12:0]        score_c_next;
    logic [7:0]         class_c_reg;

    logic               d_valid_reg;
    logic signed [50:0] prod_d_reg [CORNERS];
    logic signed [50:0] prod_d_next [CORNERS];
    logic               pass_d_reg;
    logic [12:0]        score_d_reg;
    logic [7:0]         class_d_reg;

    logic               out_valid_reg;
    logic [19:0]        corner_reg [CORNERS];
    logic [19:0]        corner_next [CORNERS];
    logic [12:0]        score_reg;
    logic [7:0]         class_reg;

    logic               b_free;
    logic               c_free;
    logic               d_free;
    logic               o_free;

    logic signed [25:0] x2;
    logic signed [25:0] y2;
    logic signed [25:0] w_ext;
    logic signed [25:0] h_ext;
    logic signed [47:0] score_full;
    logic [23:0]        ratio_sel [CORNERS];
    logic [15:0]        limit_sel [CORNERS];
    logic [19:0]        limit_q [CORNERS];
    logic [25:0]        quot [CORNERS];

    assign o_free     = !out_valid_reg || !out_stall;
    assign d_free     = !d_valid_reg || o_free;
    assign c_free     = !c_valid_reg || d_free;
    assign b_free     = !b_valid_reg || c_free;
    assign snap_ready = b_free;

    always_comb
    begin
        x2    = {snap.box_x[23], snap.box_x, 1'b0};
        y2    = {snap.box_y[23], snap.box_y, 1'b0};
        w_ext = {{2{snap.box_w[23]}}, snap.box_w};
        h_ext = {{2{snap.box_h[23]}}, snap.box_h};
        span_b_next[0] = x2 - w_ext;
        span_b_next[1] = y2 - h_ext;
        span_b_next[2] = x2 + w_ext;
        span_b_next[3] = y2 + h_ext;
        prod_b_next    = $signed(snap.objectness) * $signed(snap.best_class_score);
        obj_ok_b_next  = $signed(snap.objectness)
                         >= $signed({11'b0, cfg.score_threshold});
    end

    always_comb
    begin
        score_full  = prod_b_reg >>> SCORE_SHIFT;
        pass_c_next = obj_ok_b_reg && (score_full >= $signed({35'b0, cfg.score_threshold}));
        if (score_full > $signed({35'b0, SCORE_MAX}))
            score_c_next = SCORE_MAX;
        else
            score_c_next = score_full[12:0];
        for (int i = 0; i < CORNERS; i++)
        begin
            ratio_sel[i] = i[0] ? cfg.ratio_y : cfg.ratio_x;
            lo_c_next[i] = span_b_reg[i] * $signed({1'b0, ratio_sel[i][11:0]});
            hi_c_next[i] = span_b_reg[i] * $signed({1'b0, ratio_sel[i][23:12]});
        end
    end

    always_comb
    begin
        for (int i = 0; i < CORNERS; i++)
        begin
            prod_d_next[i] = $signed({hi_c_reg[i], 12'b0})
                             + $signed({{12{lo_c_reg[i][38]}}, lo_c_reg[i]});
        end
    end

    always_comb
    begin
        for (int i = 0; i < CORNERS; i++)
        begin
            limit_sel[i] = i[0] ? cfg.image_height : cfg.image_width;
            limit_q[i]   = {limit_sel[i], 4'b0};
            quot[i]      = prod_d_reg[i][50:CORNER_SHIFT];
            if (prod_d_reg[i][50])
                corner_next[i] = '0;
            else if (quot[i] > {6'b0, limit_q[i]})
                corner_next[i] = limit_q[i];
            else
                corner_next[i] = quot[i][19:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_free)
                b_valid_reg <= snap_valid;
            if (c_free)
                c_valid_reg <= b_valid_reg;
            if (d_free)
                d_valid_reg <= c_valid_reg;
            if (o_free)
                out_valid_reg <= d_valid_reg && pass_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_free && snap_valid)
        begin
            span_b_reg   <= span_b_next;
            prod_b_reg   <= prod_b_next;
            obj_ok_b_reg <= obj_ok_b_next;
            class_b_reg  <= snap.best_class;
        end
        if (c_free && b_valid_reg)
        begin
            lo_c_reg    <= lo_c_next;
            hi_c_reg    <= hi_c_next;
            pass_c_reg  <= pass_c_next;
            score_c_reg <= score_c_next;
            class_c_reg <= class_b_reg;
        end
        if (d_free && c_valid_reg)
        begin
            prod_d_reg  <= prod_d_next;
            pass_d_reg  <= pass_c_reg;
            score_d_reg <= score_c_reg;
            class_d_reg <= class_c_reg;
        end
        if (o_free && d_valid_reg && pass_d_reg)
        begin
            corner_reg <= corner_next;
            score_reg  <= score_d_reg;
            class_reg  <= class_d_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign left      = corner_reg[0];
    assign top       = corner_reg[1];
    assign right     = corner_reg[2];
    assign bottom    = corner_reg[3];
    assign score     = score_reg;
    assign class_id  = class_reg;

endmodule

// ===== rtl/core/detection_row_decode_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_row_decode_top: streaming detector output row decoder
// Takes one tensor value per transaction and emits a scaled, clamped box
// with score and class for each row that passes the threshold.
//
//   channel   signals                              direction
//   input     in_valid, in_stall, sample,          value in
//             frame_start
//   output    out_valid, out_stall, left, top,     box out
//             right, bottom, score, class_id
//   config    cfg_write, cfg_index, cfg_data       register write
//
// One input transaction per cycle while in_stall is low; the column counter
// and class compare settle within the accepting cycle.
// After the last value of its row is accepted, a box passes through the
// row snapshot, span and score multiply, split ratio multiply, sum, clamp.
// Reset clears the column count, row state and all valid flags.
// Output stall backs up the box pipeline; input stalls only when a row
// end snapshot cannot move into the pipeline.
// ----------------------------------------------------------------------------
module detection_row_decode_top
    import drd_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [23:0]            sample,
    input  logic                   frame_start,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [19:0]            left,
    output logic [19:0]            top,
    output logic [19:0]            right,
    output logic [19:0]            bottom,
    output logic [12:0]            score,
    output logic [7:0]             class_id,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg;
    logic snap_valid;
    logic snap_ready;
    row_t snap;

    drd_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    drd_row_track #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_row_track
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .sample      (sample),
        .frame_start (frame_start),
        .in_stall    (in_stall),
        .snap_ready  (snap_ready),
        .snap_valid  (snap_valid),
        .snap        (snap)
    );

    drd_box_pipe u_box_pipe
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (snap_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .left       (left),
        .top        (top),
        .right      (right),
        .bottom     (bottom),
        .score      (score),
        .class_id   (class_id)
    );

endmodule

// ===== test/detection_row_decode_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_row_decode_checker: box predictor and scoreboard
// Watches the value, box and register channels of the row decoder. Every
// accepted value is folded into a private copy of the row state; each row
// end that passes both thresholds queues the box it must produce. Accepted
// boxes are compared field by field against that queue in arrival order.
// ----------------------------------------------------------------------------
module detection_row_decode_checker
    import drd_pkg::*;
#(
    parameter int MAX_ROW_WIDTH = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [23:0]            sample,
    input  logic                   frame_start,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [19:0]            left,
    input  logic [19:0]            top,
    input  logic [19:0]            right,
    input  logic [19:0]            bottom,
    input  logic [12:0]            score,
    input  logic [7:0]             class_id,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     errors,
    output int                     boxes_pending
);

    typedef struct packed {
        logic [19:0] left;
        logic [19:0] top;
        logic [19:0] right;
        logic [19:0] bottom;
        logic [12:0] score;
        logic [7:0]  class_id;
    } box_t;

    cfg_t               regs;
    logic [7:0]         column;
    logic signed [23:0] box_x;
    logic signed [23:0] box_y;
    logic signed [23:0] box_w;
    logic signed [23:0] box_h;
    logic signed [23:0] objectness;
    logic signed [23:0] best_score;
    logic [7:0]         best_class;
    box_t               boxes_due[$];

    function automatic logic [19:0] scale_corner(input longint twice_centre,
                                                 input longint extent,
                                                 input bit plus,
                                                 input logic [23:0] ratio,
                                                 input logic [15:0] limit);
        longint span;
        longint prod;
        longint ceiling;
        span    = plus ? twice_centre + extent : twice_centre - extent;
        prod    = span * longint'({40'd0, ratio});
        ceiling = longint'({48'd0, limit}) * 16;
        if (prod < 0)
            return 20'd0;
        prod = prod >>> CORNER_SHIFT;
        if (prod > ceiling)
            prod = ceiling;
        return prod[19:0];
    endfunction

    task automatic check_field(input string name, input logic [19:0] want,
                               input logic [19:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    task automatic decode_value(input logic [23:0] s, input logic fs);
        logic [7:0] col;
        int         width;
        longint     combined;
        longint     threshold;
        longint     x2;
        longint     y2;
        box_t       b;
        col   = fs ? COL_BOX_X : column;
        width = int'(regs.row_width);
        if (width < int'(ROW_WIDTH_MIN))
            width = int'(ROW_WIDTH_MIN);
        if (width > MAX_ROW_WIDTH)
            width = MAX_ROW_WIDTH;

        if (col == COL_BOX_X)
            box_x = s;
        else if (col == COL_BOX_Y)
            box_y = s;
        else if (col == COL_BOX_W)
            box_w = s;
        else if (col == COL_BOX_H)
            box_h = s;
        else if (col == COL_OBJECTNESS)
            objectness = s;
        else if (col == COL_FIRST_CLASS)
        begin
            best_score = s;
            best_class = 8'd0;
        end
        else if ($signed(s) > best_score)
        begin
            best_score = s;
            best_class = col - COL_FIRST_CLASS;
        end

        if (int'(col) >= width - 1)
        begin
            combined  = (longint'(objectness) * longint'(best_score)) >>> SCORE_SHIFT;
            threshold = longint'(regs.score_threshold);
            if (longint'(objectness) >= threshold && combined >= threshold)
            begin
                x2         = 2 * longint'(box_x);
                y2         = 2 * longint'(box_y);
                b.left     = scale_corner(x2, longint'(box_w), 1'b0, regs.ratio_x,
                                          regs.image_width);
                b.top      = scale_corner(y2, longint'(box_h), 1'b0, regs.ratio_y,
                                          regs.image_height);
                b.right    = scale_corner(x2, longint'(box_w), 1'b1, regs.ratio_x,
                                          regs.image_width);
                b.bottom   = scale_corner(y2, longint'(box_h), 1'b1, regs.ratio_y,
                                          regs.image_height);
                b.score    = (combined > longint'(SCORE_MAX)) ? SCORE_MAX : combined[12:0];
                b.class_id = best_class;
                boxes_due  = {boxes_due, b};
            end
            column = 8'd0;
        end
        else
            column = col + 8'd1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        box_t got;
        box_t want;
        if (!rst_n)
        begin
            regs.score_threshold = RST_SCORE_THRESHOLD;
            regs.row_width       = RST_ROW_WIDTH;
            regs.ratio_x         = RST_RATIO;
            regs.ratio_y         = RST_RATIO;
            regs.image_width     = RST_IMAGE_SIZE;
            regs.image_height    = RST_IMAGE_SIZE;
            column               = 8'd0;
            box_x                = '0;
            box_y                = '0;
            box_w                = '0;
            box_h                = '0;
            objectness           = '0;
            best_score           = '0;
            best_class           = 8'd0;
            boxes_due.delete();
            errors               = 0;
            boxes_pending        = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {left, top, right, bottom, score, class_id};
                if (boxes_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: box expected none got %h", $time, got);
                end
                else
                begin
                    want = boxes_due.pop_front();
                    check_field("left", want.left, got.left);
                    check_field("top", want.top, got.top);
                    check_field("right", want.right, got.right);
                    check_field("bottom", want.bottom, got.bottom);
                    check_field("score", 20'(want.score), 20'(got.score));
                    check_field("class_id", 20'(want.class_id), 20'(got.class_id));
                end
            end

            if (in_valid && !in_stall)
                decode_value(sample, frame_start);

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SCORE_THRESHOLD: regs.score_threshold = cfg_data[12:0];
                    REG_ROW_WIDTH:       regs.row_width       = cfg_data[8:0];
                    REG_RATIO_X:         regs.ratio_x         = cfg_data;
                    REG_RATIO_Y:         regs.ratio_y         = cfg_data;
                    REG_IMAGE_WIDTH:     regs.image_width     = cfg_data[15:0];
                    REG_IMAGE_HEIGHT:    regs.image_height    = cfg_data[15:0];
                    default: ;
                endcase
            end

            boxes_pending = boxes_due.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: detection row decoder testbench
// Drives tensor values in bursts with random gaps, stalls the box channel
// on changing patterns (one long hold-off to back the decoder up), and
// reprograms the registers between phases once all boxes are out. A short
// directed run covers extreme boxes, a mid-row restart, threshold equality
// and class ties; random phases follow with well-formed rows and noise.
// ----------------------------------------------------------------------------
module tb;
    import drd_pkg::*;

    localparam int MAX_ROW_WIDTH   = 256;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int ITEM_BUDGET     = 1150;
    localparam int PRESSURE_PHASE  = 2;
    localparam int NARROWEST_PHASE = 4;
    localparam int WIDEST_PHASE    = 5;
    localparam int TIMEOUT_NS      = 400000;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum int { STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_TOGGLE } stall_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [23:0]            sample;
    logic                   frame_start;
    logic                   out_valid;
    logic                   out_stall;
    logic [19:0]            left;
    logic [19:0]            top;
    logic [19:0]            right;
    logic [19:0]            bottom;
    logic [12:0]            score;
    logic [7:0]             class_id;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int          errors;
    int          boxes_pending;
    bit          hold_off_req;
    bit          gaps_on;
    int          burst_left;
    int          values_sent;
    int          row_span;
    logic [12:0] cur_threshold;

    detection_row_decode_top #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left        (left),
        .top         (top),
        .right       (right),
        .bottom      (bottom),
        .score       (score),
        .class_id    (class_id),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    detection_row_decode_checker #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .frame_start   (frame_start),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left          (left),
        .top           (top),
        .right         (right),
        .bottom        (bottom),
        .score         (score),
        .class_id      (class_id),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .boxes_pending (boxes_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("detection_row_decode_top: mismatch");
        $finish;
    end

    initial
    begin : box_sink
        stall_mode_t mode;
        int          seg_len;
        bit          held;
        out_stall = 1'b0;
        held      = 1'b0;
        forever
        begin
            if (hold_off_req && !held)
            begin
                held = 1'b1;
                repeat (HOLD_OFF_CYCLES)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            mode    = stall_mode_t'($urandom_range(0, 3));
            seg_len = $urandom_range(1, 40);
            repeat (seg_len)
            begin
                @(negedge clk);
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ~out_stall;
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_value(input logic [23:0] value, input logic fs);
        int gap;
        if (gaps_on && burst_left <= 0)
        begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid    <= 1'b0;
                sample      <= 24'($urandom);
                frame_start <= 1'($urandom_range(0, 1));
            end
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        sample      <= value;
        frame_start <= fs;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        values_sent++;
    endtask

    // drop valid, wait out every box, then let the pipeline go quiet
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (boxes_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [23:0] box_value(input bit extent);
        case ($urandom_range(0, 9))
            0, 1, 2: return 24'($urandom);
            default: return extent ? 24'($urandom_range(0, 300 * 4096))
                                   : 24'($urandom_range(0, 700 * 4096));
        endcase
    endfunction

    function automatic logic [23:0] objectness_value();
        case ($urandom_range(0, 9))
            0, 1:    return 24'($urandom);
            2, 3:    return 24'($urandom_range(0, 4096));
            default: return 24'(cur_threshold + $urandom_range(0, 6000));
        endcase
    endfunction

    function automatic logic [23:0] class_value(input logic [23:0] prev);
        case ($urandom_range(0, 9))
            0:       return 24'($urandom);
            1, 2:    return prev;
            default: return 24'($urandom_range(0, 9000));
        endcase
    endfunction

    function automatic logic [23:0] pick_ratio();
        case ($urandom_range(0, 7))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom);
            default: return 24'($urandom_range(32768, 131072));
        endcase
    endfunction

    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 7))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(64, 4096));
        endcase
    endfunction

    task automatic send_row(input bit fs_first);
        logic [23:0] value;
        logic [23:0] prev;
        logic        fs;
        prev = '0;
        for (int c = 0; c < row_span; c++)
        begin
            if (c < int'(COL_BOX_W))
                value = box_value(1'b0);
            else if (c < int'(COL_OBJECTNESS))
                value = box_value(1'b1);
            else if (c == int'(COL_OBJECTNESS))
                value = objectness_value();
            else
            begin
                value = class_value(prev);
                prev  = value;
            end
            fs = (c == 0 && fs_first) || ($urandom_range(0, 49) == 0);
            send_value(value, fs);
        end
    endtask

    task automatic program_phase(input int p);
        logic [23:0] data;
        logic [12:0] thr;
        logic [8:0]  rw;
        case ($urandom_range(0, 6))
            0:       thr = 13'd0;
            1:       thr = SCORE_MAX;
            2:       thr = 13'h1FFF;
            default: thr = 13'($urandom_range(0, 4096));
        endcase
        if (p == PRESSURE_PHASE)
            thr = 13'd0;

        if (p == PRESSURE_PHASE)
            rw = ROW_WIDTH_MIN;
        else if (p == WIDEST_PHASE)
            rw = 9'h1FF;
        else if (p == NARROWEST_PHASE)
            rw = 9'd0;
        else
        begin
            case ($urandom_range(0, 9))
                0:       rw = 9'($urandom_range(0, 5));
                1:       rw = 9'($urandom_range(15, 40));
                default: rw = 9'($urandom_range(6, 14));
            endcase
        end

        data       = 24'($urandom);
        data[12:0] = thr;
        write_reg(REG_SCORE_THRESHOLD, data);
        data       = 24'($urandom);
        data[8:0]  = rw;
        write_reg(REG_ROW_WIDTH, data);
        write_reg(REG_RATIO_X, pick_ratio());
        write_reg(REG_RATIO_Y, pick_ratio());
        data       = 24'($urandom);
        data[15:0] = pick_size();
        write_reg(REG_IMAGE_WIDTH, data);
        data       = 24'($urandom);
        data[15:0] = pick_size();
        write_reg(REG_IMAGE_HEIGHT, data);
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 24'($urandom));

        cur_threshold = thr;
        if (rw < ROW_WIDTH_MIN)
            row_span = int'(ROW_WIDTH_MIN);
        else if (rw > MAX_ROW_WIDTH)
            row_span = MAX_ROW_WIDTH;
        else
            row_span = int'(rw);
    endtask

    initial
    begin : stimulus
        int rows;
        int tail;
        in_valid      = 1'b0;
        sample        = '0;
        frame_start   = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        rst_n         = 1'b0;
        hold_off_req  = 1'b0;
        gaps_on       = 1'b0;
        burst_left    = 0;
        values_sent   = 0;
        cur_threshold = RST_SCORE_THRESHOLD;
        row_span      = int'(RST_ROW_WIDTH);
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // width below the minimum runs as six
        write_reg(REG_ROW_WIDTH, 24'd3);
        row_span = int'(ROW_WIDTH_MIN);
        // extreme box: x clamps on both edges, y falls below zero
        send_value(24'h7FFFFF, 1'b1); send_value(24'h800000, 1'b0);
        send_value(24'h800000, 1'b0); send_value(24'h7FFFFF, 1'b0);
        send_value(24'd4096, 1'b0);   send_value(24'd4096, 1'b0);
        // restart mid-row, then objectness and score equal to the threshold
        send_value(24'd409600, 1'b0); send_value(24'd204800, 1'b0);
        send_value(24'd81920, 1'b0);
        send_value(24'd1310720, 1'b1); send_value(24'd983040, 1'b0);
        send_value(24'd409600, 1'b0);  send_value(24'd204800, 1'b0);
        send_value(24'd1024, 1'b0);    send_value(24'd4096, 1'b0);
        settle();

        write_reg(REG_SPARE_LO, 24'hFFFFFF);
        write_reg(REG_ROW_WIDTH, 24'd8);
        row_span = 8;
        // negative first class, then a tie: the earlier class keeps it
        send_value(24'd1310720, 1'b1); send_value(24'd983040, 1'b0);
        send_value(24'd409600, 1'b0);  send_value(24'd204800, 1'b0);
        send_value(24'd4096, 1'b0);    send_value(24'hFFFF9C, 1'b0);
        send_value(24'd3500, 1'b0);    send_value(24'd3500, 1'b0);
        settle();

        for (int phase = 0; values_sent < ITEM_BUDGET; phase++)
        begin
            program_phase(phase);
            gaps_on    = (phase % 4 != 3) && (phase != PRESSURE_PHASE);
            burst_left = 0;
            if (phase == PRESSURE_PHASE)
            begin
                @(posedge clk);
                hold_off_req = 1'b1;
                rows         = 30;
            end
            else if (row_span > 40)
                rows = 1;
            else if (row_span > 14)
                rows = $urandom_range(1, 3);
            else
                rows = $urandom_range(4, 14);

            for (int r = 0; r < rows; r++)
                send_row(r == 0 ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0));

            // leave a partial row so the next width lands mid-row
            if ($urandom_range(0, 1))
            begin
                tail = $urandom_range(1, (row_span > 10) ? 9 : row_span - 1);
                repeat (tail) send_value(24'($urandom), 1'b0);
            end
            settle();
        end

        if (errors == 0)
            $display("detection_row_decode_top: match");
        else
            $display("detection_row_decode_top: mismatch");
        $finish;
    end

endmodule
